// File: design/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    localparam logic [YEAR_W-1:0]  TOP_YEAR  = YEAR_W'(16383);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_28    = DAY_W'(28);
    localparam logic [DAY_W-1:0]   DAY_29    = DAY_W'(29);
    localparam logic [DAY_W-1:0]   DAY_30    = DAY_W'(30);
    localparam logic [DAY_W-1:0]   DAY_31    = DAY_W'(31);

    // Packed structs list the top bits first, so the first field sits highest.
    typedef struct packed {
        logic [1:0]         pad;
        logic [YEAR_W-1:0]  year_b;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
        logic [YEAR_W-1:0]  year_a;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic               a_before_b;
        logic               dates_equal;
        logic               prev_underflow;
        logic [YEAR_W-1:0]  prev_year;
        logic [MONTH_W-1:0] prev_month;
        logic [DAY_W-1:0]   prev_day;
        logic               next_overflow;
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_day;
        logic               b_is_valid;
        logic               a_is_valid;
    } result_t;

    // Leap rule is year divisible by 4, no century exception.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB) begin
            len = (y[1:0] == 2'b00) ? DAY_29 : DAY_28;
        end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
            len = DAY_30;
        end else begin
            len = DAY_31;
        end
        return len;
    endfunction

    function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [YEAR_W-1:0] y);
        return (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d >= DAY_FIRST)
            && (d <= month_len(m, y));
    endfunction

endpackage

`default_nettype wire

// File: design/calendar_date_step_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Ports                        | Payload
// ---------+-----+------------------------------+-------------------------------------
// input    | in  | s_tvalid, s_tready, s_tdata  | date pair A and B (48 bits)
// result   | out | m_tvalid, m_tready, m_tdata  | validity, next/prev of A, compare (56 bits)
//
// One transfer in, one transfer out. Each pair passes an input register,
// then the date logic into the result register. Throughput is one pair per cycle while m_tready is high.
// aresetn (synchronous, active low) clears both valid flags; payload is not reset.
// A stall on m_tready holds the result; the input register keeps taking a
// transfer while it is empty or the result register can move on in the same cycle.

module calendar_date_step_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [4:0] day_a, [8:5] month_a, [22:9] year_a,
    // [27:23] day_b, [31:28] month_b, [45:32] year_b, [47:46] zero
    input  wire logic [cds_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] a_is_valid, [1] b_is_valid, [6:2] next_day, [10:7] next_month,
    // [24:11] next_year, [25] next_overflow, [30:26] prev_day,
    // [34:31] prev_month, [48:35] prev_year, [49] prev_underflow,
    // [50] dates_equal, [51] a_before_b, [55:52] zero
    output logic [cds_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    // Stage 1: input register
    logic              in_valid_reg;
    logic              in_valid_next;
    cds_pkg::in_item_t in_item_reg;

    // Stage 2: result register
    logic              out_valid_reg;
    logic              out_valid_next;
    cds_pkg::result_t  res_reg;
    cds_pkg::result_t  res_next;

    logic out_free;
    logic advance;
    logic s_take;

    // Result register can load when empty or when its transfer completes now.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= cds_pkg::in_item_t'(s_tdata);
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Date logic
    logic [cds_pkg::DAY_W-1:0]   da, db;
    logic [cds_pkg::MONTH_W-1:0] ma, mb;
    logic [cds_pkg::YEAR_W-1:0]  ya, yb;
    logic                        va, vb;
    logic [cds_pkg::DAY_W-1:0]   len_a;
    logic [cds_pkg::MONTH_W-1:0] pm_dec;

    always_comb begin
        da = in_item_reg.day_a;
        ma = in_item_reg.month_a;
        ya = in_item_reg.year_a;
        db = in_item_reg.day_b;
        mb = in_item_reg.month_b;
        yb = in_item_reg.year_b;
        va = cds_pkg::date_ok(da, ma, ya);
        vb = cds_pkg::date_ok(db, mb, yb);
        len_a  = cds_pkg::month_len(ma, ya);
        pm_dec = ma - cds_pkg::MONTH_JAN;

        res_next = '0;
        res_next.a_is_valid = va;
        res_next.b_is_valid = vb;

        if (va) begin
            // following date
            if (da < len_a) begin
                res_next.next_day   = da + cds_pkg::DAY_FIRST;
                res_next.next_month = ma;
                res_next.next_year  = ya;
            end else if (ma < cds_pkg::MONTH_DEC) begin
                res_next.next_day   = cds_pkg::DAY_FIRST;
                res_next.next_month = ma + cds_pkg::MONTH_JAN;
                res_next.next_year  = ya;
            end else if (ya < cds_pkg::TOP_YEAR) begin
                res_next.next_day   = cds_pkg::DAY_FIRST;
                res_next.next_month = cds_pkg::MONTH_JAN;
                res_next.next_year  = ya + cds_pkg::YEAR_W'(1);
            end else begin
                res_next.next_day      = da;
                res_next.next_month    = ma;
                res_next.next_year     = ya;
                res_next.next_overflow = 1'b1;
            end

            // preceding date
            if (da > cds_pkg::DAY_FIRST) begin
                res_next.prev_day   = da - cds_pkg::DAY_FIRST;
                res_next.prev_month = ma;
                res_next.prev_year  = ya;
            end else if (ma > cds_pkg::MONTH_JAN) begin
                res_next.prev_day   = cds_pkg::month_len(pm_dec, ya);
                res_next.prev_month = pm_dec;
                res_next.prev_year  = ya;
            end else if (ya != '0) begin
                res_next.prev_day   = cds_pkg::DAY_31;
                res_next.prev_month = cds_pkg::MONTH_DEC;
                res_next.prev_year  = ya - cds_pkg::YEAR_W'(1);
            end else begin
                res_next.prev_day       = da;
                res_next.prev_month     = ma;
                res_next.prev_year      = ya;
                res_next.prev_underflow = 1'b1;
            end
        end

        if (va && vb) begin
            res_next.dates_equal = (da == db) && (ma == mb) && (ya == yb);
            if (ya != yb) begin
                res_next.a_before_b = ya < yb;
            end else if (ma != mb) begin
                res_next.a_before_b = ma < mb;
            end else begin
                res_next.a_before_b = da < db;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cds_pkg::OUT_TDATA_W'(res_reg);

    // Assertions
    a_eq_lt_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_reg.dates_equal && res_reg.a_before_b))
        else $error("equal and before both set");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res_reg.a_is_valid) |->
            (res_reg.next_day == '0 && res_reg.prev_day == '0 &&
             !res_reg.next_overflow && !res_reg.prev_underflow &&
             !res_reg.dates_equal && !res_reg.a_before_b))
        else $error("invalid A produced nonzero step result");

    a_overflow_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.next_overflow) |->
            (res_reg.next_year == cds_pkg::TOP_YEAR &&
             res_reg.next_month == cds_pkg::MONTH_DEC &&
             res_reg.next_day == cds_pkg::DAY_31))
        else $error("overflow without saturated next date");

    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced item missing at result register");

    a_stall_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("stalled input item dropped");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RANDOM_PAIRS = 1150;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Keeps the dates expected back from the block, oldest first.
    class date_scoreboard;
        cds_pkg::result_t pending_results[$];
        int unsigned      errors;
        int unsigned      pairs_taken;

        static function logic [cds_pkg::DAY_W-1:0] days_in(logic [cds_pkg::MONTH_W-1:0] m,
                                                            logic [cds_pkg::YEAR_W-1:0] y);
            if (m == cds_pkg::MONTH_FEB)
                return (y % 4 == 0) ? cds_pkg::DAY_29 : cds_pkg::DAY_28;
            if (m == cds_pkg::MONTH_APR || m == cds_pkg::MONTH_JUN
                || m == cds_pkg::MONTH_SEP || m == cds_pkg::MONTH_NOV)
                return cds_pkg::DAY_30;
            return cds_pkg::DAY_31;
        endfunction

        static function logic is_real_date(logic [cds_pkg::DAY_W-1:0] d,
                                           logic [cds_pkg::MONTH_W-1:0] m,
                                           logic [cds_pkg::YEAR_W-1:0] y);
            return m >= cds_pkg::MONTH_JAN && m <= cds_pkg::MONTH_DEC && d != 0
                && d <= days_in(m, y);
        endfunction

        function cds_pkg::result_t step_dates(cds_pkg::in_item_t p);
            cds_pkg::result_t r;
            logic             a_ok;
            logic             b_ok;
            r    = '0;
            a_ok = is_real_date(p.day_a, p.month_a, p.year_a);
            b_ok = is_real_date(p.day_b, p.month_b, p.year_b);
            r.a_is_valid = a_ok;
            r.b_is_valid = b_ok;
            if (a_ok) begin
                // following day; holds at the last day of the top year
                r.next_year = p.year_a;
                if (p.day_a < days_in(p.month_a, p.year_a)) begin
                    r.next_day   = cds_pkg::DAY_W'(p.day_a + 1);
                    r.next_month = p.month_a;
                end else if (p.month_a < cds_pkg::MONTH_DEC) begin
                    r.next_day   = cds_pkg::DAY_FIRST;
                    r.next_month = cds_pkg::MONTH_W'(p.month_a + 1);
                end else if (p.year_a < cds_pkg::TOP_YEAR) begin
                    r.next_day   = cds_pkg::DAY_FIRST;
                    r.next_month = cds_pkg::MONTH_JAN;
                    r.next_year  = cds_pkg::YEAR_W'(p.year_a + 1);
                end else begin
                    r.next_day      = p.day_a;
                    r.next_month    = p.month_a;
                    r.next_overflow = 1'b1;
                end
                // preceding day; holds at the first day of year zero
                r.prev_year = p.year_a;
                if (p.day_a > cds_pkg::DAY_FIRST) begin
                    r.prev_day   = cds_pkg::DAY_W'(p.day_a - 1);
                    r.prev_month = p.month_a;
                end else if (p.month_a > cds_pkg::MONTH_JAN) begin
                    r.prev_month = cds_pkg::MONTH_W'(p.month_a - 1);
                    r.prev_day   = days_in(r.prev_month, p.year_a);
                end else if (p.year_a != 0) begin
                    r.prev_day   = cds_pkg::DAY_31;
                    r.prev_month = cds_pkg::MONTH_DEC;
                    r.prev_year  = cds_pkg::YEAR_W'(p.year_a - 1);
                end else begin
                    r.prev_day       = p.day_a;
                    r.prev_month     = p.month_a;
                    r.prev_underflow = 1'b1;
                end
            end
            if (a_ok && b_ok) begin
                r.dates_equal = p.day_a == p.day_b && p.month_a == p.month_b
                             && p.year_a == p.year_b;
                if (p.year_a != p.year_b)
                    r.a_before_b = p.year_a < p.year_b;
                else if (p.month_a != p.month_b)
                    r.a_before_b = p.month_a < p.month_b;
                else
                    r.a_before_b = p.day_a < p.day_b;
            end
            return r;
        endfunction

        function void note_pair(cds_pkg::in_item_t p);
            pending_results.push_back(step_dates(p));
            pairs_taken++;
        endfunction

        local function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(cds_pkg::result_t got);
            cds_pkg::result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            cmp_field("a_is_valid",     16'(want.a_is_valid),     16'(got.a_is_valid));
            cmp_field("b_is_valid",     16'(want.b_is_valid),     16'(got.b_is_valid));
            cmp_field("next_day",       16'(want.next_day),       16'(got.next_day));
            cmp_field("next_month",     16'(want.next_month),     16'(got.next_month));
            cmp_field("next_year",      16'(want.next_year),      16'(got.next_year));
            cmp_field("next_overflow",  16'(want.next_overflow),  16'(got.next_overflow));
            cmp_field("prev_day",       16'(want.prev_day),       16'(got.prev_day));
            cmp_field("prev_month",     16'(want.prev_month),     16'(got.prev_month));
            cmp_field("prev_year",      16'(want.prev_year),      16'(got.prev_year));
            cmp_field("prev_underflow", 16'(want.prev_underflow), 16'(got.prev_underflow));
            cmp_field("dates_equal",    16'(want.dates_equal),    16'(got.dates_equal));
            cmp_field("a_before_b",     16'(want.a_before_b),     16'(got.a_before_b));
            cmp_field("pad",            16'(want.pad),            16'(got.pad));
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [cds_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [cds_pkg::OUT_TDATA_W-1:0] m_tdata;

    date_scoreboard sb = new();

    calendar_date_step_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Transfers are taken from the values seen just before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_pair(cds_pkg::in_item_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(cds_pkg::result_t'(m_tdata));
        end
    end

    task automatic send_pair(input cds_pkg::in_item_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n == 0)
            return;
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    function automatic cds_pkg::in_item_t pack_dates(int unsigned da, int unsigned ma,
                                                     int unsigned ya, int unsigned db,
                                                     int unsigned mb, int unsigned yb);
        cds_pkg::in_item_t p;
        p         = '0;
        p.day_a   = cds_pkg::DAY_W'(da);
        p.month_a = cds_pkg::MONTH_W'(ma);
        p.year_a  = cds_pkg::YEAR_W'(ya);
        p.day_b   = cds_pkg::DAY_W'(db);
        p.month_b = cds_pkg::MONTH_W'(mb);
        p.year_b  = cds_pkg::YEAR_W'(yb);
        return p;
    endfunction

    // Dates biased toward month ends and the ends of the year range.
    function automatic void pick_date(output logic [cds_pkg::DAY_W-1:0] d,
                                      output logic [cds_pkg::MONTH_W-1:0] m,
                                      output logic [cds_pkg::YEAR_W-1:0] y);
        logic [cds_pkg::DAY_W-1:0] len;
        case ($urandom_range(0, 5))
            0:       y = cds_pkg::YEAR_W'($urandom_range(0, 3));
            1:       y = cds_pkg::YEAR_W'(cds_pkg::TOP_YEAR - $urandom_range(0, 3));
            2:       y = cds_pkg::YEAR_W'($urandom_range(0, 16383) & 14'h3FFC);
            default: y = cds_pkg::YEAR_W'($urandom_range(0, 16383));
        endcase
        m   = cds_pkg::MONTH_W'(($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                                             : $urandom_range(0, 15));
        len = date_scoreboard::days_in(m, y);
        case ($urandom_range(0, 5))
            0:       d = cds_pkg::DAY_FIRST;
            1:       d = len;
            2:       d = cds_pkg::DAY_W'(len - 1);
            3:       d = cds_pkg::DAY_W'(len + 1);
            4:       d = cds_pkg::DAY_W'($urandom_range(0, 31));
            default: d = cds_pkg::DAY_W'($urandom_range(1, len));
        endcase
    endfunction

    task automatic run_directed();
        send_pair(pack_dates(0, 0, 0, 0, 0, 0));
        send_pair(pack_dates(31, 15, 16383, 31, 15, 16383));
        send_pair(pack_dates(31, 12, 16383, 1, 1, 0));        // top of range
        send_pair(pack_dates(1, 1, 0, 31, 12, 16383));        // bottom of range
        send_pair(pack_dates(28, 2, 2001, 28, 2, 2001));
        send_pair(pack_dates(29, 2, 2000, 29, 2, 2001));      // leap A, bad B
        send_pair(pack_dates(29, 2, 1900, 28, 2, 1900));      // no century rule
        send_pair(pack_dates(1, 3, 2004, 1, 3, 2003));
        send_pair(pack_dates(1, 3, 2003, 1, 3, 2004));
        send_pair(pack_dates(30, 4, 2010, 31, 4, 2010));
        send_pair(pack_dates(1, 5, 2010, 30, 4, 2010));       // A month above B month
        send_pair(pack_dates(30, 4, 2010, 1, 5, 2010));
        send_pair(pack_dates(31, 12, 2023, 1, 1, 2024));
        send_pair(pack_dates(1, 1, 2024, 31, 12, 2023));
        send_pair(pack_dates(0, 6, 100, 15, 6, 100));         // day zero
        send_pair(pack_dates(15, 0, 100, 15, 13, 100));       // month out of range
        send_pair(pack_dates(10, 13, 16383, 10, 14, 0));
        send_pair(pack_dates(31, 7, 5000, 31, 8, 5000));
        send_pair(pack_dates(14, 9, 7000, 15, 9, 7000));
        send_pair(pack_dates(15, 9, 7000, 14, 9, 7000));
        send_pair(pack_dates(1, 12, 7000, 31, 1, 7001));      // earlier year, later month
        send_pair(pack_dates(1, 1, 1, 29, 2, 16380));
        send_pair(pack_dates(1, 3, 16380, 0, 0, 0));
    endtask

    task automatic run_random(input int unsigned n);
        cds_pkg::in_item_t p;
        logic [63:0]       noise;
        int unsigned       sent_cnt;
        int unsigned       burst;
        int unsigned       k;
        sent_cnt = 0;
        while (sent_cnt < n) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent_cnt < n; k++) begin
                p = '0;
                pick_date(p.day_a, p.month_a, p.year_a);
                p.day_b   = p.day_a;
                p.month_b = p.month_a;
                p.year_b  = p.year_a;
                case ($urandom_range(0, 5))
                    0:       ;
                    1:       p.day_b = cds_pkg::DAY_W'($urandom_range(0, 31));
                    2:       p.month_b = cds_pkg::MONTH_W'($urandom_range(1, 12));
                    3:       p.year_b = cds_pkg::YEAR_W'(p.year_a + $urandom_range(0, 2) - 1);
                    default: pick_date(p.day_b, p.month_b, p.year_b);
                endcase
                if ($urandom_range(0, 19) == 0) begin
                    noise = {$urandom, $urandom};
                    p     = cds_pkg::in_item_t'(noise[cds_pkg::IN_TDATA_W-1:0]);
                    p.pad = '0;
                end
                send_pair(p);
                sent_cnt++;
            end
            // one stretch runs back to back with no sender gaps
            if (sent_cnt < 500 || sent_cnt > 700)
                pause_sender($urandom_range(0, 6));
        end
    endtask

    // Result side: random stall patterns that change over the run, plus one long hold-off.
    initial begin : result_sink
        int unsigned      cyc;
        int unsigned      hold_left;
        bit               held_once;
        int unsigned      mode;
        logic [15:0]      stall_mask;
        cyc        = 0;
        hold_left  = 0;
        held_once  = 1'b0;
        mode       = 0;
        stall_mask = 16'hFFFF;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held_once && sb.pairs_taken >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (cyc % 48 == 0) begin
                    mode       = $urandom_range(0, 3);
                    stall_mask = 16'($urandom);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= stall_mask[cyc[3:0]];
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (cyc % 8) < 5;
                endcase
            end
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random(RANDOM_PAIRS);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
